// ===== hdl/esdf_pkg.sv =====
// ----------------------------------------------------------------------------
// esdf_pkg: shared types and constants for the elevator stop and dispatch core
// Holds the floor and button geometry, the state and command codes, and the
// packed item, result and state records used by every module of the block.
// ----------------------------------------------------------------------------
package esdf_pkg;

    localparam int FLOORS  = 4;
    localparam int BUTTONS = 3;
    localparam int ID_BITS = 2;

    localparam int FLOOR_W = 2;
    localparam int ACT_W   = FLOORS * BUTTONS;
    localparam int OWN_W   = ACT_W * ID_BITS;

    // Button slots within one floor of the order table.
    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_CAB  = 2;

    typedef enum logic [1:0] {
        FUNC_EXEC    = 2'd0,
        FUNC_ARRIVE  = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_DOOR   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        DIR_DOWN = 2'd0,
        DIR_STOP = 2'd1,
        DIR_UP   = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        TMR_NONE = 2'd0,
        TMR_DOOR = 2'd1,
        TMR_COND = 2'd2
    } t_tmr;

    typedef enum logic [1:0] {
        MOTOR_NONE = 2'd0,
        MOTOR_STOP = 2'd1,
        MOTOR_UP   = 2'd2,
        MOTOR_DOWN = 2'd3
    } t_motor;

    typedef enum logic [1:0] {
        LAMP_NONE = 2'd0,
        LAMP_ON   = 2'd1,
        LAMP_OFF  = 2'd2
    } t_lamp;

    typedef enum logic [1:0] {
        TSTART_NONE = 2'd0,
        TSTART_DOOR = 2'd1,
        TSTART_COND = 2'd2
    } t_tstart;

    // Input item payload, floor in the lowest bits as on the stream.
    typedef struct packed {
        logic [OWN_W-1:0]   owner;
        logic [ACT_W-1:0]   active;
        logic [FLOOR_W-1:0] floor;
    } t_item;

    // Result item, motor command in the lowest bits as on the stream.
    typedef struct packed {
        t_dir               dir_now;
        t_mode              mode_now;
        logic               stopped;
        logic [ACT_W-1:0]   clear_mask;
        logic               tmr_stop;
        t_tstart            tmr_start;
        logic [FLOOR_W-1:0] ind_floor;
        logic               ind_write;
        t_lamp              lamp;
        t_motor             motor;
    } t_result;

    typedef struct packed {
        t_mode              mode;
        t_dir               dir;
        logic [FLOOR_W-1:0] last_floor;
        t_tmr               tmr;
    } t_state;

    // Order table summary for the floor carried by the event.
    typedef struct packed {
        logic [BUTTONS-1:0] act_at;
        logic [BUTTONS-1:0] own_at;
        logic               own_below;
        logic               own_above;
    } t_ord_info;

endpackage

// ===== hdl/elevator_stop_and_dispatch_fsm_core.sv =====
// ----------------------------------------------------------------------------
// elevator_stop_and_dispatch_fsm_core: elevator stop and dispatch controller
// Takes button, sensor and timer events with an order table snapshot and
// returns motor, door lamp, indicator, timer and order clearing commands.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                Payload
// -------  ---------  -----------------------  --------------------------------
// s        in         i_s_tvalid / o_s_tready  i_s_tdata (40 b), i_s_tuser (2 b)
// m        out        o_m_tvalid / i_m_tready  o_m_tdata (32 b)
// cfg      in         i_cfg_valid/o_cfg_ready  i_cfg_data (2 b), own elevator id
//
// One event is accepted per clock cycle while the result side takes results.
// An event lands in the input register, is evaluated there against the
// controller state and moves into the result register, where its result is
// offered, once that register is empty or being emptied. The single decision
// stage (order lookup plus next-state logic) sits between the two registers;
// the controller state updates as each event enters the result register. When
// the result side stalls, the input register holds one more event and then
// the input side stalls. Reset is synchronous and active low, holds both ready
// outputs low, and returns the car to idle, direction stop, floor zero and no
// timer.
// ----------------------------------------------------------------------------
module elevator_stop_and_dispatch_fsm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: floor [1:0], order_active [13:2],
    // order_owner [37:14], zero fill [39:38].
    input  logic [39:0] i_s_tdata,
    // Fields from bit 0 up: func [1:0].
    input  logic [1:0]  i_s_tuser,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: motor_cmd [1:0], door_lamp_cmd [3:2],
    // indicator_write [4], indicator_floor [6:5], timer_start_cmd [8:7],
    // timer_stop_cmd [9], clear_mask [21:10], stopped [22], mode_now [24:23],
    // dir_now [26:25], zero fill [31:27].
    output logic [31:0] o_m_tdata,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int RES_W = $bits(esdf_pkg::t_result);
    localparam int ITM_W = $bits(esdf_pkg::t_item);

    // Input register stage.
    logic               r_in_valid;
    logic               n_in_valid;
    esdf_pkg::t_item    r_in_item;
    esdf_pkg::t_func    r_in_func;

    // Result register stage.
    logic               r_out_valid;
    logic               n_out_valid;
    esdf_pkg::t_result  r_out_res;

    // Controller state and configuration.
    esdf_pkg::t_state             r_state;
    esdf_pkg::t_state             n_state;
    logic [esdf_pkg::ID_BITS-1:0] r_own_id;

    esdf_pkg::t_ord_info info;
    esdf_pkg::t_result   n_res;

    logic s_accept;
    logic advance;

    // The input register moves into the result register whenever the result
    // register is empty or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || advance);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = i_rst_n;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    esdf_orders u_orders (
        .i_active (r_in_item.active),
        .i_owner  (r_in_item.owner),
        .i_own_id (r_own_id),
        .i_floor  (r_in_item.floor),
        .o_info   (info)
    );

    esdf_decide u_decide (
        .i_state (r_state),
        .i_func  (r_in_func),
        .i_floor (r_in_item.floor),
        .i_info  (info),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_own_id    <= '0;
            r_state     <= '{mode: esdf_pkg::MODE_IDLE, dir: esdf_pkg::DIR_STOP,
                             last_floor: '0, tmr: esdf_pkg::TMR_NONE};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_own_id <= i_cfg_data[esdf_pkg::ID_BITS-1:0];
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item <= esdf_pkg::t_item'(i_s_tdata[ITM_W-1:0]);
            r_in_func <= esdf_pkg::t_func'(i_s_tuser);
        end
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(32 - RES_W)'(0), r_out_res};

    // A held event is never dropped while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input register lost an event");

    // Every event that leaves the input register shows up as a result.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced event did not reach the result register");

    // With the door open the car has no direction and the door timer runs.
    a_door_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == esdf_pkg::MODE_DOOR) |->
            (r_state.dir == esdf_pkg::DIR_STOP && r_state.tmr == esdf_pkg::TMR_DOOR))
        else $error("door open without stop direction and door timer");

    // A stop result always reports the door open mode.
    a_stop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.stopped) |-> (r_out_res.mode_now == esdf_pkg::MODE_DOOR))
        else $error("stop reported without door open mode");

endmodule

// ===== hdl/esdf_orders.sv =====
// ----------------------------------------------------------------------------
// esdf_orders: order table lookup
// Reduces the order snapshot to the buttons active and owned at the event
// floor and to flags for owned orders below and above that floor.
// ----------------------------------------------------------------------------
module esdf_orders (
    input  logic [esdf_pkg::ACT_W-1:0]   i_active,
    input  logic [esdf_pkg::OWN_W-1:0]   i_owner,
    input  logic [esdf_pkg::ID_BITS-1:0] i_own_id,
    input  logic [esdf_pkg::FLOOR_W-1:0] i_floor,
    output esdf_pkg::t_ord_info          o_info
);

    logic [esdf_pkg::ACT_W-1:0]  owned;
    logic [esdf_pkg::FLOORS-1:0] floor_owned;

    always_comb begin
        for (int k = 0; k < esdf_pkg::ACT_W; k++) begin
            owned[k] = i_active[k]
                && (i_owner[k*esdf_pkg::ID_BITS +: esdf_pkg::ID_BITS] == i_own_id);
        end
        for (int fl = 0; fl < esdf_pkg::FLOORS; fl++) begin
            floor_owned[fl] = |owned[fl*esdf_pkg::BUTTONS +: esdf_pkg::BUTTONS];
        end
    end

    always_comb begin
        o_info = '0;
        for (int fl = 0; fl < esdf_pkg::FLOORS; fl++) begin
            if (esdf_pkg::FLOOR_W'(fl) == i_floor) begin
                o_info.act_at = i_active[fl*esdf_pkg::BUTTONS +: esdf_pkg::BUTTONS];
                o_info.own_at = owned[fl*esdf_pkg::BUTTONS +: esdf_pkg::BUTTONS];
            end
            if (esdf_pkg::FLOOR_W'(fl) < i_floor) begin
                o_info.own_below = o_info.own_below | floor_owned[fl];
            end
            if (esdf_pkg::FLOOR_W'(fl) > i_floor) begin
                o_info.own_above = o_info.own_above | floor_owned[fl];
            end
        end
    end

endmodule

// ===== hdl/esdf_decide.sv =====
// ----------------------------------------------------------------------------
// esdf_decide: controller next-state and command logic
// Given the controller state, the event kind and floor and the order summary,
// forms the next state and the full command record for one event.
// ----------------------------------------------------------------------------
module esdf_decide (
    input  esdf_pkg::t_state             i_state,
    input  esdf_pkg::t_func              i_func,
    input  logic [esdf_pkg::FLOOR_W-1:0] i_floor,
    input  esdf_pkg::t_ord_info          i_info,
    output esdf_pkg::t_state             o_state,
    output esdf_pkg::t_result            o_res
);

    logic                         do_arrive;
    logic                         must_stop;
    logic                         open;
    logic [esdf_pkg::BUTTONS-1:0] clr_bits;
    esdf_pkg::t_state             st;
    esdf_pkg::t_result            res;

    // Stop rule while moving: a hall call in the travel direction, a cab
    // call, or no owned call further on.
    always_comb begin
        case (i_state.dir)
            esdf_pkg::DIR_DOWN: must_stop = i_info.own_at[esdf_pkg::BTN_DOWN]
                || i_info.own_at[esdf_pkg::BTN_CAB] || !i_info.own_below;
            esdf_pkg::DIR_UP:   must_stop = i_info.own_at[esdf_pkg::BTN_UP]
                || i_info.own_at[esdf_pkg::BTN_CAB] || !i_info.own_above;
            default:            must_stop = 1'b0;
        endcase
    end

    always_comb begin
        st        = i_state;
        res       = '0;
        do_arrive = 1'b0;
        open      = 1'b0;
        clr_bits  = '0;

        case (i_func)
            esdf_pkg::FUNC_EXEC: begin
                if (i_state.last_floor == i_floor) begin
                    if (i_state.mode == esdf_pkg::MODE_MOVING
                            || i_state.mode == esdf_pkg::MODE_IDLE) begin
                        do_arrive = 1'b1;
                    end
                end else if (i_state.mode == esdf_pkg::MODE_IDLE) begin
                    res.tmr_start = esdf_pkg::TSTART_COND;
                    st.tmr        = esdf_pkg::TMR_COND;
                    st.mode       = esdf_pkg::MODE_MOVING;
                    if (i_state.last_floor > i_floor) begin
                        res.motor = esdf_pkg::MOTOR_DOWN;
                        st.dir    = esdf_pkg::DIR_DOWN;
                    end else begin
                        res.motor = esdf_pkg::MOTOR_UP;
                        st.dir    = esdf_pkg::DIR_UP;
                    end
                end
            end
            esdf_pkg::FUNC_ARRIVE: begin
                do_arrive = 1'b1;
            end
            esdf_pkg::FUNC_TIMEOUT: begin
                st.mode  = esdf_pkg::MODE_IDLE;
                res.lamp = esdf_pkg::LAMP_OFF;
                if (i_state.tmr == esdf_pkg::TMR_DOOR) begin
                    res.tmr_stop = 1'b1;
                    st.tmr       = esdf_pkg::TMR_NONE;
                end
                clr_bits = i_info.own_at;
            end
            default: begin
            end
        endcase

        if (do_arrive) begin
            res.ind_write = 1'b1;
            res.ind_floor = i_floor;
            st.last_floor = i_floor;
            if (i_state.mode == esdf_pkg::MODE_MOVING) begin
                if (must_stop) begin
                    res.motor = esdf_pkg::MOTOR_STOP;
                    open      = 1'b1;
                    clr_bits  = '1;
                end
            end else if (i_state.mode == esdf_pkg::MODE_IDLE) begin
                if (|i_info.act_at) begin
                    open     = 1'b1;
                    clr_bits = i_info.act_at;
                end
            end
        end

        // Door opening: a travel condition timer is cancelled, and the door
        // timer is started unless it is already running.
        if (open) begin
            if (i_state.tmr == esdf_pkg::TMR_COND) begin
                res.tmr_stop = 1'b1;
            end
            if (i_state.tmr != esdf_pkg::TMR_DOOR) begin
                res.lamp      = esdf_pkg::LAMP_ON;
                res.tmr_start = esdf_pkg::TSTART_DOOR;
            end
            st.tmr  = esdf_pkg::TMR_DOOR;
            st.dir  = esdf_pkg::DIR_STOP;
            st.mode = esdf_pkg::MODE_DOOR;
        end
        res.stopped = open && (i_func == esdf_pkg::FUNC_ARRIVE);

        for (int fl = 0; fl < esdf_pkg::FLOORS; fl++) begin
            if (esdf_pkg::FLOOR_W'(fl) == i_floor) begin
                res.clear_mask[fl*esdf_pkg::BUTTONS +: esdf_pkg::BUTTONS] = clr_bits;
            end
        end

        res.mode_now = st.mode;
        res.dir_now  = st.dir;
    end

    assign o_state = st;
    assign o_res   = res;

endmodule

// ===== sim/elevator_stop_and_dispatch_fsm_core_tb.sv =====
// ----------------------------------------------------------------------------
// elevator_stop_and_dispatch_fsm_core_tb: self-checking bench for the core
// Sends button, sensor and timer events into the event stream and predicts the
// command word of every event with a behavioral model of the car controller.
// A directed opening covers the corner cases. Random trips follow, mostly
// well-formed and partly noise, under four stall patterns and all own ids.
// ----------------------------------------------------------------------------
module elevator_stop_and_dispatch_fsm_core_tb;

    localparam int PHASES      = 4;
    localparam int TRIP_EVENTS = 431;
    localparam int STALL_LIMIT = 4000;

    // The scoreboard carries its own copy of the car state and the own id. It
    // predicts the command word of each accepted event and matches it later
    // against the result stream, in order.
    class car_scoreboard;
        esdf_pkg::t_mode    mode;
        esdf_pkg::t_dir     dir;
        logic [1:0]         last_floor;
        esdf_pkg::t_tmr     tmr;
        logic [1:0]         own_id;
        esdf_pkg::t_item    ev;
        esdf_pkg::t_result  res;
        esdf_pkg::t_result  expected_cmds[$];
        int                 errors;
        int                 n_checked;
        int                 n_stops;

        function new();
            mode       = esdf_pkg::MODE_IDLE;
            dir        = esdf_pkg::DIR_STOP;
            last_floor = '0;
            tmr        = esdf_pkg::TMR_NONE;
            own_id     = '0;
            errors     = 0;
            n_checked  = 0;
            n_stops    = 0;
        endfunction

        function void set_own_id(logic [1:0] id);
            own_id = id;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function bit owned(int f, int b);
            int k;
            k = f * esdf_pkg::BUTTONS + b;
            return ev.active[k]
                && (ev.owner[k*esdf_pkg::ID_BITS +: esdf_pkg::ID_BITS] == own_id);
        endfunction

        function bit any_owned(int lo, int hi);
            for (int f = lo; f < hi && f < esdf_pkg::FLOORS; f++) begin
                for (int b = 0; b < esdf_pkg::BUTTONS; b++) begin
                    if (owned(f, b)) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // A running travel timer gives way to the door timer; a door timer
        // that already runs is kept and the lamp is left alone.
        function void open_car_door();
            res.stopped = 1'b1;
            if (tmr == esdf_pkg::TMR_COND) begin
                res.tmr_stop = 1'b1;
                tmr = esdf_pkg::TMR_NONE;
            end
            if (tmr == esdf_pkg::TMR_NONE) begin
                res.lamp      = esdf_pkg::LAMP_ON;
                res.tmr_start = esdf_pkg::TSTART_DOOR;
                tmr = esdf_pkg::TMR_DOOR;
            end
            dir  = esdf_pkg::DIR_STOP;
            mode = esdf_pkg::MODE_DOOR;
        endfunction

        function void arrive(logic [1:0] fl);
            bit stop;
            int f;
            f = fl;
            res.ind_write = 1'b1;
            res.ind_floor = fl;
            last_floor    = fl;
            if (mode == esdf_pkg::MODE_MOVING) begin
                // Stop for a hall call in the travel direction, a cab call, or
                // when none of this car's orders lie further on.
                if (dir == esdf_pkg::DIR_DOWN)
                    stop = owned(f, esdf_pkg::BTN_DOWN) || owned(f, esdf_pkg::BTN_CAB) ||
                           !any_owned(0, f);
                else if (dir == esdf_pkg::DIR_UP)
                    stop = owned(f, esdf_pkg::BTN_UP) || owned(f, esdf_pkg::BTN_CAB) ||
                           !any_owned(f + 1, esdf_pkg::FLOORS);
                else
                    stop = 1'b0;
                if (stop) begin
                    res.motor = esdf_pkg::MOTOR_STOP;
                    open_car_door();
                    for (int b = 0; b < esdf_pkg::BUTTONS; b++)
                        res.clear_mask[f*esdf_pkg::BUTTONS+b] = 1'b1;
                end
            end else if (mode == esdf_pkg::MODE_IDLE) begin
                // An idle car serves any active order at the floor, whoever owns it.
                for (int b = 0; b < esdf_pkg::BUTTONS; b++) begin
                    if (ev.active[f*esdf_pkg::BUTTONS+b]) begin
                        open_car_door();
                        res.clear_mask[f*esdf_pkg::BUTTONS+b] = 1'b1;
                    end
                end
            end
        endfunction

        function void predict_event(logic [1:0] fn, esdf_pkg::t_item it);
            ev  = it;
            res = '0;
            case (fn)
                esdf_pkg::FUNC_EXEC: begin
                    if (mode == esdf_pkg::MODE_MOVING) begin
                        if (last_floor == it.floor) arrive(last_floor);
                    end else if (mode == esdf_pkg::MODE_IDLE) begin
                        if (last_floor == it.floor) begin
                            arrive(last_floor);
                        end else begin
                            res.tmr_start = esdf_pkg::TSTART_COND;
                            tmr  = esdf_pkg::TMR_COND;
                            mode = esdf_pkg::MODE_MOVING;
                            if (last_floor > it.floor) begin
                                res.motor = esdf_pkg::MOTOR_DOWN;
                                dir = esdf_pkg::DIR_DOWN;
                            end else begin
                                res.motor = esdf_pkg::MOTOR_UP;
                                dir = esdf_pkg::DIR_UP;
                            end
                        end
                    end
                    res.stopped = 1'b0;
                end
                esdf_pkg::FUNC_ARRIVE: begin
                    arrive(it.floor);
                end
                esdf_pkg::FUNC_TIMEOUT: begin
                    mode     = esdf_pkg::MODE_IDLE;
                    res.lamp = esdf_pkg::LAMP_OFF;
                    if (tmr == esdf_pkg::TMR_DOOR) begin
                        res.tmr_stop = 1'b1;
                        tmr = esdf_pkg::TMR_NONE;
                    end
                    for (int b = 0; b < esdf_pkg::BUTTONS; b++) begin
                        if (owned(it.floor, b))
                            res.clear_mask[it.floor*esdf_pkg::BUTTONS+b] = 1'b1;
                    end
                end
                default: ;
            endcase
            res.mode_now = mode;
            res.dir_now  = dir;
            expected_cmds.push_back(res);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] word);
            esdf_pkg::t_result got;
            esdf_pkg::t_result want;
            got = esdf_pkg::t_result'(word[$bits(esdf_pkg::t_result)-1:0]);
            if (expected_cmds.size() == 0) begin
                $error("result 0x%h arrived with no event waiting for it", word);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            n_checked++;
            if (got.stopped) n_stops++;
            cmp_field("motor_cmd",       want.motor,      got.motor);
            cmp_field("door_lamp_cmd",   want.lamp,       got.lamp);
            cmp_field("indicator_write", want.ind_write,  got.ind_write);
            cmp_field("indicator_floor", want.ind_floor,  got.ind_floor);
            cmp_field("timer_start_cmd", want.tmr_start,  got.tmr_start);
            cmp_field("timer_stop_cmd",  want.tmr_stop,   got.tmr_stop);
            cmp_field("clear_mask",      want.clear_mask, got.clear_mask);
            cmp_field("stopped",         want.stopped,    got.stopped);
            cmp_field("mode_now",        want.mode_now,   got.mode_now);
            cmp_field("dir_now",         want.dir_now,    got.dir_now);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [39:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_cfg_ready;

    car_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_sent        = 0;
    int stall_cycles  = 0;

    elevator_stop_and_dispatch_fsm_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random back-pressure and an in-order check of every transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic esdf_pkg::t_item mk_item(logic [1:0] fl,
                                                logic [esdf_pkg::ACT_W-1:0] act,
                                                logic [esdf_pkg::OWN_W-1:0] own);
        esdf_pkg::t_item it;
        it.floor  = fl;
        it.active = act;
        it.owner  = own;
        return it;
    endfunction

    // Order table with the given density; most owners are this car.
    function automatic esdf_pkg::t_item rand_item(logic [1:0] fl, int dens);
        esdf_pkg::t_item it;
        it.floor = fl;
        for (int k = 0; k < esdf_pkg::ACT_W; k++) begin
            it.active[k] = ($urandom_range(99) < dens);
            if ($urandom_range(99) < 60)
                it.owner[k*esdf_pkg::ID_BITS +: esdf_pkg::ID_BITS] = sb.own_id;
            else
                it.owner[k*esdf_pkg::ID_BITS +: esdf_pkg::ID_BITS] =
                    esdf_pkg::ID_BITS'($urandom_range(3));
        end
        return it;
    endfunction

    task automatic send_event(logic [1:0] fn, esdf_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= fn;
        i_s_tdata  <= {2'b00, it};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.predict_event(fn, it);
        n_sent++;
    endtask

    // Lets every expected result come back, plus the pipeline depth.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_own_id(logic [1:0] id);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= id;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_own_id(id);
    endtask

    // One step of a trip: dispatch from idle, floor arrivals in the travel
    // direction, door timeouts. A share of the events is random noise.
    task automatic random_step();
        logic [1:0] fn;
        logic [1:0] fl;
        int         dens;
        dens = ($urandom_range(3) == 0) ? 60 : $urandom_range(5, 30);
        if ($urandom_range(99) < 15) begin
            fn   = 2'($urandom_range(3));
            fl   = 2'($urandom_range(3));
            dens = $urandom_range(100);
        end else begin
            case (sb.mode)
                esdf_pkg::MODE_IDLE: begin
                    fn = esdf_pkg::FUNC_EXEC;
                    fl = 2'($urandom_range(3));
                    if (fl == sb.last_floor && $urandom_range(3) != 0)
                        fl = fl ^ 2'($urandom_range(1, 3));
                end
                esdf_pkg::MODE_MOVING: begin
                    fn = esdf_pkg::FUNC_ARRIVE;
                    if (sb.dir == esdf_pkg::DIR_UP && sb.last_floor != 2'd3)
                        fl = sb.last_floor + 2'd1;
                    else if (sb.dir == esdf_pkg::DIR_DOWN && sb.last_floor != 2'd0)
                        fl = sb.last_floor - 2'd1;
                    else
                        fl = sb.last_floor;
                    if ($urandom_range(99) < 10) begin
                        fn = esdf_pkg::FUNC_EXEC;
                        fl = 2'($urandom_range(3));
                    end
                end
                default: begin
                    fn = esdf_pkg::FUNC_TIMEOUT;
                    fl = ($urandom_range(99) < 10) ? 2'($urandom_range(3)) : sb.last_floor;
                end
            endcase
        end
        send_event(fn, rand_item(fl, dens));
    endtask

    initial begin
        logic [1:0] phase_ids[PHASES]   = '{2'd0, 2'd3, 2'd1, 2'd2};
        int         phase_send[PHASES]  = '{0, 66, 0, 18};
        int         phase_stall[PHASES] = '{0, 0, 66, 18};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_own_id(2'd0);

        // Directed opening with own id 0, no idling on either side.
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd0, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd3, 12'h000, 24'h000000));
        // Moving up: a hall-down order at this floor and an order above: pass by.
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd1, 12'h810, 24'h000000));
        // Hall-up here belongs to another car: pass by.
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd2, 12'h840, 24'h001000));
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd3, 12'h800, 24'h000000));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd3, 12'hFFF, 24'h000000));
        // Every order active but none owned: moving down stops at once.
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd0, 12'hFFF, 24'hFFFFFF));
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd2, 12'hFFF, 24'hFFFFFF));
        // Door open: arrival only rewrites the indicator and execute changes nothing.
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd2, 12'hFFF, 24'hFFFFFF));
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd1, 12'hFFF, 24'hFFFFFF));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd2, 12'hFFF, 24'hFFFFFF));
        // Idle arrival with foreign orders on every button.
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd1, 12'hFFF, 24'hFFFFFF));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd1, 12'h000, 24'h000000));
        // Unknown event kind.
        send_event(2'd3,                   mk_item(2'd3, 12'hFFF, 24'hFFFFFF));
        // Execute at the car's own floor behaves as an arrival, without stopped.
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd1, 12'h010, 24'h000000));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd1, 12'hFFF, 24'h000000));
        // Timeout while moving leaves the travel timer running; the next door
        // opening has to stop it.
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd3, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd2, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd2, 12'h100, 24'h000000));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd2, 12'h000, 24'h000000));
        // Execute while moving: elsewhere ignored, at the last floor an arrival.
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd0, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd0, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_EXEC,    mk_item(2'd2, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_TIMEOUT, mk_item(2'd2, 12'h000, 24'h000000));
        send_event(esdf_pkg::FUNC_ARRIVE,  mk_item(2'd0, 12'h000, 24'h000000));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_own_id(phase_ids[ph]);
            send_idle_pct = phase_send[ph];
            stall_pct     = phase_stall[ph];
            for (int n = 0; n < TRIP_EVENTS; n++) random_step();
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d events: directed corner cases, then random trips with own ids",
                 n_sent);
        $display("0, 3, 1, 2 under four stall patterns; %0d results checked, %0d stops.",
                 sb.n_checked, sb.n_stops);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
